// ===== design/assert_macros.svh =====
// Assertion macros included by the checker file, wdma_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is low.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== design/wdma_pkg.sv =====
// ----------------------------------------------------------------------------
// wdma_pkg
// Shared widths, register map and mask bit positions for the wall detector.
// ----------------------------------------------------------------------------
package wdma_pkg;

   localparam int DIST_W   = 16;
   localparam int MASK_W   = 3;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Register index, taken from byte address bit 2
   localparam logic REG_WALL_THRESHOLD = 1'b0;

   localparam logic [DIST_W-1:0] THRESHOLD_RESET = 16'd100;

   // Mask bit positions
   localparam int BIT_LEFT   = 2;
   localparam int BIT_CENTER = 1;
   localparam int BIT_RIGHT  = 0;

   typedef logic [DIST_W-1:0] dist_type;
   typedef logic [MASK_W-1:0] mask_type;

endpackage

// ===== design/wdma_csr.sv =====
// ----------------------------------------------------------------------------
// wdma_csr
// APB register block: holds the wall threshold and its window-scaled copy.
// ----------------------------------------------------------------------------
module wdma_csr #(
   parameter int SUM_W  = 19,
   parameter int WINDOW = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [wdma_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [wdma_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [wdma_pkg::CSR_DW-1:0] csr_prdata,
   output logic                    csr_pready,
   output logic [SUM_W-1:0]        thr_scaled
);
   import wdma_pkg::*;

   dist_type         thr_ff;
   dist_type         thr_in;
   logic [SUM_W-1:0] thr_scaled_ff;
   logic [SUM_W-1:0] thr_scaled_in;
   logic             wr_en;

   // avg < thr  <=>  sum < thr * WINDOW, so keep the product ready
   assign wr_en         = csr_psel && csr_penable && csr_pwrite
                          && (csr_paddr[2] == REG_WALL_THRESHOLD);
   assign thr_in        = wr_en ? csr_pwdata[DIST_W-1:0] : thr_ff;
   assign thr_scaled_in = SUM_W'(thr_in) * SUM_W'(WINDOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= THRESHOLD_RESET;
         thr_scaled_ff <= SUM_W'(THRESHOLD_RESET) * SUM_W'(WINDOW);
      end else begin
         thr_ff        <= thr_in;
         thr_scaled_ff <= thr_scaled_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_WALL_THRESHOLD) begin
         csr_prdata = CSR_DW'(thr_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign thr_scaled = thr_scaled_ff;

endmodule

// ===== design/wdma_window.sv =====
// ----------------------------------------------------------------------------
// wdma_window
// One distance channel: shift line of the last WINDOW samples, running sum
// and the below-threshold compare on the updated sum.
// ----------------------------------------------------------------------------
module wdma_window #(
   parameter int SUM_W  = 19,
   parameter int WINDOW = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  wdma_pkg::dist_type    sample,
   input  logic [SUM_W-1:0]      thr_scaled,
   output logic                  below
);
   import wdma_pkg::*;

   dist_type         win_ff [WINDOW];
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;

   // drop the oldest tap, add the new sample
   assign sum_in = sum_ff - SUM_W'(win_ff[WINDOW-1]) + SUM_W'(sample);
   assign below  = sum_in < thr_scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (advance) begin
         win_ff[0] <= sample;
         for (int i = 1; i < WINDOW; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== design/wall_detect_moving_average.sv =====
// ----------------------------------------------------------------------------
// wall_detect_moving_average
// Three-sided wall detector on moving averages of range distances.
// ----------------------------------------------------------------------------
// Each req beat carries one left/center/right distance sample in millimetres.
// The sample enters a per-side window of the last WINDOW samples, and the
// rsp beat carries a 3-bit mask: bit 2 left, bit 1 center, bit 0 right, set
// when that side's truncated window average is below the threshold register.
// A beat accepted at one edge shows on rsp the next cycle. Throughput is one
// beat per cycle unless a held result is stalled, set by the single update
// of the running sums; the compare runs against threshold * WINDOW,
// precomputed at register write time. Reset clears the windows, the running
// sums and the rsp valid flag, and sets the threshold to 100; early averages
// include the cleared entries. While rsp is stalled the result is held; req
// stalls only when the result register is full and not being taken. The
// threshold register sits at byte address 0 of the APB port; the user is to
// write it only while the block is idle. The block does not enforce this.
// ----------------------------------------------------------------------------
module wall_detect_moving_average #(
   parameter int WINDOW = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  wdma_pkg::dist_type           req_left_mm,
   input  wdma_pkg::dist_type           req_center_mm,
   input  wdma_pkg::dist_type           req_right_mm,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output wdma_pkg::mask_type           rsp_wall_mask,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [wdma_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [wdma_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [wdma_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import wdma_pkg::*;

   localparam int SUM_W = DIST_W + $clog2(WINDOW);

   logic [SUM_W-1:0] thr_scaled;
   logic             accept;
   logic             below_l;
   logic             below_c;
   logic             below_r;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   mask_type         mask_ff;
   mask_type         mask_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   wdma_csr #(.SUM_W(SUM_W), .WINDOW(WINDOW)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .thr_scaled  (thr_scaled)
   );

   wdma_window #(.SUM_W(SUM_W), .WINDOW(WINDOW)) u_left (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .sample     (req_left_mm),
      .thr_scaled (thr_scaled),
      .below      (below_l)
   );

   wdma_window #(.SUM_W(SUM_W), .WINDOW(WINDOW)) u_center (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .sample     (req_center_mm),
      .thr_scaled (thr_scaled),
      .below      (below_c)
   );

   wdma_window #(.SUM_W(SUM_W), .WINDOW(WINDOW)) u_right (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .sample     (req_right_mm),
      .thr_scaled (thr_scaled),
      .below      (below_r)
   );

   always_comb begin
      mask_in             = '0;
      mask_in[BIT_LEFT]   = below_l;
      mask_in[BIT_CENTER] = below_c;
      mask_in[BIT_RIGHT]  = below_r;
   end

   // hold while stalled, load on accept, drop once taken
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mask_ff <= mask_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_wall_mask = mask_ff;

endmodule

// ===== design/wdma_checker.sv =====
// ----------------------------------------------------------------------------
// wdma_checker
// Port-level checks on the wall detector's handshake and result timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wdma_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  wdma_pkg::mask_type  rsp_wall_mask
);

   // output register empties on reset
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_valid)

   // req only stalls behind a held result
   `ASSERT_CLK_RST(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall))

   // every accepted beat shows a result next cycle
   `ASSERT_CLK_RST(a_one_cycle, clock, reset, (req_valid && !req_stall) |=> rsp_valid)

   // a taken result with no new beat leaves the output empty
   `ASSERT_CLK_RST(a_no_extra, clock, reset,
      (rsp_valid && !rsp_stall && !(req_valid && !req_stall)) |=> !rsp_valid)

   // a stalled result holds
   `ASSERT_CLK_RST(a_hold, clock, reset,
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_wall_mask)))

endmodule

bind wall_detect_moving_average wdma_checker u_wdma_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_wall_mask (rsp_wall_mask)
);

// ===== tb/tb_wall_detect_moving_average.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wall_detect_moving_average
// Self-checking bench for the three-sided moving-average wall detector.
// ----------------------------------------------------------------------------
// A local model keeps its own sample windows, running sums and threshold. It
// predicts the wall mask for every accepted req beat, and each rsp beat is
// checked against the oldest prediction. Directed samples cover zero-filled
// early windows, averages on the threshold, truncation, field extremes, zero
// and full-scale thresholds and a write to an unused address. Random phases
// run under several thresholds with random idling on both sides, a long rsp
// hold that backs the block up, and a final stream with no idling at all.
// ----------------------------------------------------------------------------
module tb_wall_detect_moving_average;
   import wdma_pkg::*;

   localparam int WINDOW        = 8;
   localparam int IDLE_LIMIT    = 1000;
   localparam int PRINT_CAP     = 30;
   localparam logic [CSR_AW-1:0] ADDR_THRESHOLD = {REG_WALL_THRESHOLD, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_UNUSED    = 3'd4;

   typedef enum int {MIX_FULL, MIX_NEAR, MIX_LOW, MIX_EDGE} mix_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_stall;
   dist_type           req_left_mm   = '0;
   dist_type           req_center_mm = '0;
   dist_type           req_right_mm  = '0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   mask_type           rsp_wall_mask;
   logic               csr_psel      = 1'b0;
   logic               csr_penable   = 1'b0;
   logic               csr_pwrite    = 1'b0;
   logic [CSR_AW-1:0]  csr_paddr     = '0;
   logic [CSR_DW-1:0]  csr_pwdata    = '0;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;

   // Local copy of the detector state
   dist_type           side_win [3][WINDOW];
   logic [31:0]        side_sum [3];
   int unsigned        next_slot;
   dist_type           thr_model;

   mask_type           expected_masks[$];
   int                 mismatch_count  = 0;
   int                 idle_cycles     = 0;
   bit                 sender_idle_on  = 1'b1;
   bit                 receiver_idle_on = 1'b1;
   int                 long_hold_req   = 0;
   int                 stall_left      = 0;

   wall_detect_moving_average #(.WINDOW(WINDOW)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_mm   (req_left_mm),
      .req_center_mm (req_center_mm),
      .req_right_mm  (req_right_mm),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_wall_mask (rsp_wall_mask),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("mismatch: %s", msg);
      end
   endtask

   function automatic void reset_predictor();
      for (int s = 0; s < 3; s++) begin
         side_sum[s] = '0;
         for (int k = 0; k < WINDOW; k++) begin
            side_win[s][k] = '0;
         end
      end
      next_slot = 0;
      thr_model = THRESHOLD_RESET;
   endfunction

   // Push the sample into each window, then compare the new averages
   function automatic mask_type predict_wall_mask(dist_type l, dist_type c, dist_type r);
      dist_type    d [3];
      logic [31:0] avg [3];
      int unsigned slot;
      mask_type    m;
      d[0] = l;
      d[1] = c;
      d[2] = r;
      slot = (next_slot < WINDOW) ? next_slot : 0;
      for (int s = 0; s < 3; s++) begin
         side_sum[s] = side_sum[s] - side_win[s][slot] + d[s];
         side_win[s][slot] = d[s];
         avg[s] = side_sum[s] / WINDOW;
      end
      next_slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
      m = '0;
      m[BIT_LEFT]   = (avg[0] < thr_model);
      m[BIT_CENTER] = (avg[1] < thr_model);
      m[BIT_RIGHT]  = (avg[2] < thr_model);
      return m;
   endfunction

   // Predict on every accepted req beat, check every accepted rsp beat
   always @(posedge clock) begin
      mask_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_masks.push_back(predict_wall_mask(req_left_mm, req_center_mm,
                                                       req_right_mm));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_masks.size() == 0) begin
               report_mismatch($sformatf("unexpected rsp beat, wall_mask %0d",
                                         rsp_wall_mask));
            end else begin
               want = expected_masks.pop_front();
               if (rsp_wall_mask !== want) begin
                  report_mismatch($sformatf("wall_mask got %0d expected %0d",
                                            rsp_wall_mask, want));
               end
            end
         end
      end
   end

   // Receiver: long holds on request, short random stall bursts otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (long_hold_req != 0) begin
            stall_left = long_hold_req;
            long_hold_req = 0;
         end else if (stall_left == 0 && receiver_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6);
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Offer one beat and hold it until taken; maybe leave a gap after it
   task automatic send_sample(dist_type l, dist_type c, dist_type r);
      req_valid     <= 1'b1;
      req_left_mm   <= l;
      req_center_mm <= c;
      req_right_mm  <= r;
      do @(posedge clock); while (req_stall);
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_masks.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] data);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_THRESHOLD) begin
         thr_model = data[DIST_W-1:0];
      end
      // leave the bus idle before the next transfer
      @(posedge clock);
   endtask

   task automatic check_threshold_readback();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_THRESHOLD;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[DIST_W-1:0] !== thr_model) begin
         report_mismatch($sformatf("threshold read %0d expected %0d",
                                   csr_prdata[DIST_W-1:0], thr_model));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_threshold(dist_type thr);
      csr_write(ADDR_THRESHOLD, {16'($urandom), thr});
      check_threshold_readback();
   endtask

   function automatic dist_type pick_distance(mix_type kind, dist_type thr);
      int v;
      case (kind)
         MIX_NEAR: begin
            // land averages on either side of the threshold
            v = int'(thr) + int'($urandom_range(0, 255)) - 128;
         end
         MIX_LOW: begin
            v = $urandom_range(0, 255);
         end
         MIX_EDGE: begin
            case ($urandom_range(0, 2))
               0: v = 0;
               1: v = 65535;
               default: v = $urandom_range(0, 65535);
            endcase
         end
         default: begin
            v = $urandom_range(0, 65535);
         end
      endcase
      if (v < 0) begin
         v = 0;
      end
      if (v > 65535) begin
         v = 65535;
      end
      return dist_type'(v);
   endfunction

   task automatic send_random_samples(int count);
      mix_type kind;
      kind = MIX_FULL;
      for (int n = 0; n < count; n++) begin
         // keep one flavor for a run of samples so the averages settle
         if (n % 16 == 0) begin
            kind = mix_type'($urandom_range(0, 3));
         end
         send_sample(pick_distance(kind, thr_model), pick_distance(kind, thr_model),
                     pick_distance(kind, thr_model));
      end
   endtask

   // Cleared windows pull the first averages down
   task automatic test_reset_defaults();
      check_threshold_readback();
      send_sample(16'd0, 16'd65535, 16'd799);
      send_sample(16'd0, 16'd0, 16'd1);
   endtask

   // Samples on the threshold value and one below it, then truncated sums
   task automatic test_average_edges();
      set_threshold(16'd100);
      repeat (4) send_sample(16'd100, 16'd100, 16'd99);
      repeat (4) send_sample(16'd807, 16'd800, 16'd799);
   endtask

   task automatic test_threshold_limits();
      set_threshold(16'd0);
      send_sample(16'd0, 16'd0, 16'd0);
      send_sample(16'hAAAA, 16'h5555, 16'd0);
      set_threshold(16'd65535);
      repeat (8) send_sample(16'd65535, 16'd65535, 16'd65534);
      // writes to an unused address must leave the threshold alone
      csr_write(ADDR_UNUSED, 32'd0);
      check_threshold_readback();
      send_sample(16'h5555, 16'hAAAA, 16'hFFFF);
   endtask

   task automatic test_random_phases();
      set_threshold(16'd1);
      send_random_samples(200);
      set_threshold(16'd65534);
      send_random_samples(200);
      set_threshold(dist_type'($urandom_range(0, 65535)));
      send_random_samples(200);
      set_threshold(dist_type'($urandom_range(0, 2000)));
      send_random_samples(200);
      set_threshold(THRESHOLD_RESET);
      send_random_samples(200);
   endtask

   // Hold rsp for a long stretch while req keeps offering beats
   task automatic test_backpressure();
      bit keep_idle;
      keep_idle = sender_idle_on;
      sender_idle_on = 1'b0;
      long_hold_req = 64;
      send_random_samples(30);
      sender_idle_on = keep_idle;
      wait_drained();
   endtask

   task automatic test_steady_stream();
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      set_threshold(dist_type'($urandom_range(50, 3000)));
      send_random_samples(250);
   endtask

   initial begin
      reset_predictor();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_average_edges();
      test_threshold_limits();
      test_random_phases();
      test_backpressure();
      test_steady_stream();
      wait_drained();
      repeat (4) @(posedge clock);
      if (expected_masks.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_masks.size()));
      end
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
